// ===== hw/rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int BUF_DEPTH_DEFAULT = 256;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SLAVE_TX_LENGTH = 2'd1;
  localparam logic [1:0] REG_SLAVE_RX_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD         = 2'd0,
    OP_REQUEST      = 2'd1,
    OP_STATUS       = 2'd2,
    OP_SERVICE_DONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_DATA  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_STOP  = 3'd5,
    CMD_IDLE  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_WRITE = 2'd1,
    DONE_READ  = 2'd2,
    DONE_ERROR = 2'd3
  } done_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ERROR = 3'd1,
    MODE_MT    = 3'd2,
    MODE_MR    = 3'd3,
    MODE_ST    = 3'd4,
    MODE_SR    = 3'd5
  } mode_t;

  typedef enum logic [4:0] {
    STS_START                 = 5'd0,
    STS_REP_START             = 5'd1,
    STS_ARB_LOST              = 5'd2,
    STS_MT_SLA_ACK            = 5'd3,
    STS_MT_SLA_NACK           = 5'd4,
    STS_MT_DATA_ACK           = 5'd5,
    STS_MT_DATA_NACK          = 5'd6,
    STS_MR_SLA_ACK            = 5'd7,
    STS_MR_SLA_NACK           = 5'd8,
    STS_MR_DATA_ACK           = 5'd9,
    STS_MR_DATA_NACK          = 5'd10,
    STS_ST_SLA_ACK            = 5'd11,
    STS_ST_ARB_LOST_SLA_ACK   = 5'd12,
    STS_ST_DATA_ACK           = 5'd13,
    STS_ST_DATA_NACK          = 5'd14,
    STS_ST_LAST_DATA          = 5'd15,
    STS_SR_SLA_ACK            = 5'd16,
    STS_SR_ARB_LOST_SLA_ACK   = 5'd17,
    STS_SR_GCALL_ACK          = 5'd18,
    STS_SR_ARB_LOST_GCALL_ACK = 5'd19,
    STS_SR_DATA_ACK           = 5'd20,
    STS_SR_DATA_NACK          = 5'd21,
    STS_SR_GCALL_DATA_ACK     = 5'd22,
    STS_SR_GCALL_DATA_NACK    = 5'd23,
    STS_SR_STOP               = 5'd24,
    STS_NO_INFO               = 5'd25,
    STS_BUS_ERROR             = 5'd26
  } status_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [8:0] slave_tx_length;
    logic [8:0] slave_rx_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cms_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_cfg
  import i2cms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_OWN_ADDRESS:     cfg.own_address <= pwdata[7:0];
        REG_SLAVE_TX_LENGTH: cfg.slave_tx_length <= pwdata[8:0];
        REG_SLAVE_RX_LIMIT:  cfg.slave_rx_limit <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OWN_ADDRESS:     prdata = CFG_DATA_W'(cfg.own_address);
      REG_SLAVE_TX_LENGTH: prdata = CFG_DATA_W'(cfg.slave_tx_length);
      REG_SLAVE_RX_LIMIT:  prdata = CFG_DATA_W'(cfg.slave_rx_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_seq
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT,
  localparam int AW = $clog2(BUF_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    op,
  input  wire logic [4:0]    bus_status,
  input  wire logic [7:0]    received_byte,
  input  wire logic [7:0]    load_index,
  input  wire logic [7:0]    load_byte,
  input  wire logic [7:0]    target_address,
  input  wire logic [8:0]    transfer_length,
  output logic               ram_we,
  output logic      [AW-1:0] ram_waddr,
  output logic      [7:0]    ram_wdata,
  output logic      [AW-1:0] ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  output logic               strobe,
  output logic      [2:0]    bus_command,
  output logic      [7:0]    send_byte,
  output logic               received_valid,
  output logic      [7:0]    received_data,
  output logic      [7:0]    received_index,
  output logic      [1:0]    done_event,
  output logic      [8:0]    byte_count,
  output logic               failed,
  output logic               busy_res
);

  localparam logic [8:0] LEN_MAX = (BUF_DEPTH > 511) ? 9'd511 : 9'(BUF_DEPTH);

  function automatic logic [8:0] clamp_len(input logic [8:0] v);
    clamp_len = (int'(v) > BUF_DEPTH) ? LEN_MAX : v;
  endfunction

  // item held for its processing cycle
  logic       pend;
  op_t        item_op;
  logic [4:0] item_status;
  logic [7:0] item_rx;
  logic [7:0] item_li;
  logic [7:0] item_lb;
  logic [7:0] item_ta;
  logic [8:0] item_tl;

  logic [8:0] position, position_next;
  logic [8:0] end_position, end_position_next;
  logic [8:0] transfer_count, transfer_count_next;
  mode_t      mode, mode_next;
  logic [7:0] request_address, request_address_next;
  logic       slave_enabled, slave_enabled_next;
  logic       error_flag, error_flag_next;

  cmd_t       cmd;
  done_t      done;
  logic [7:0] send;
  logic       rv;
  logic [7:0] rd;
  logic [7:0] ri;
  logic       avail;
  logic       slave_on;
  logic       accept;
  logic       st_sla_in;

  assign busy = pend;
  assign accept = start && !pend;
  // slave transmit address beats begin at entry zero
  assign st_sla_in = (op == OP_STATUS)
                  && (bus_status inside {STS_ST_SLA_ACK, STS_ST_ARB_LOST_SLA_ACK});
  assign ram_raddr = (accept && st_sla_in) ? '0 : AW'(position);
  assign ram_we = pend && (item_op == OP_LOAD) && (int'(item_li) < BUF_DEPTH);
  assign ram_waddr = AW'(item_li);
  assign ram_wdata = item_lb;

  assign avail = position < end_position;
  assign slave_on = (cfg.own_address != 8'd0) && slave_enabled;

  always_comb begin
    position_next = position;
    end_position_next = end_position;
    transfer_count_next = transfer_count;
    mode_next = mode;
    request_address_next = request_address;
    slave_enabled_next = slave_enabled;
    error_flag_next = error_flag;
    cmd = CMD_NONE;
    done = DONE_NONE;
    send = 8'd0;
    rv = 1'b0;
    rd = 8'd0;
    ri = 8'd0;
    case (item_op)
      OP_LOAD: begin
      end
      OP_REQUEST: begin
        request_address_next = item_ta;
        position_next = 9'd0;
        end_position_next = clamp_len(item_tl);
        transfer_count_next = 9'd0;
        mode_next = item_ta[0] ? MODE_MR : MODE_MT;
        error_flag_next = 1'b0;
        cmd = CMD_START;
      end
      OP_STATUS: begin
        case (status_t'(item_status))
          STS_START, STS_REP_START: begin
            send = request_address;
            cmd = CMD_DATA;
          end
          STS_ARB_LOST: begin
            cmd = CMD_IDLE;
            mode_next = MODE_ERROR;
            error_flag_next = 1'b1;
          end
          STS_MT_SLA_ACK, STS_MT_DATA_ACK: begin
            if (avail) begin
              send = ram_rdata;
              cmd = CMD_DATA;
              position_next = position + 9'd1;
              transfer_count_next = transfer_count + 9'd1;
            end else begin
              cmd = CMD_STOP;
              mode_next = MODE_IDLE;
              done = DONE_WRITE;
            end
          end
          STS_MT_DATA_NACK: begin
            cmd = CMD_STOP;
            mode_next = MODE_IDLE;
            done = DONE_WRITE;
          end
          STS_MT_SLA_NACK, STS_MR_SLA_NACK: begin
            cmd = CMD_STOP;
            mode_next = MODE_ERROR;
            error_flag_next = 1'b1;
            done = DONE_ERROR;
          end
          STS_MR_SLA_ACK: begin
            cmd = (({1'b0, position} + 10'd1) < {1'b0, end_position}) ? CMD_ACK : CMD_NACK;
          end
          STS_MR_DATA_ACK: begin
            if (avail) begin
              rv = 1'b1;
              rd = item_rx;
              ri = position[7:0];
              position_next = position + 9'd1;
              transfer_count_next = transfer_count + 9'd1;
            end
            cmd = (({1'b0, position_next} + 10'd1) < {1'b0, end_position})
                ? CMD_ACK : CMD_NACK;
          end
          STS_MR_DATA_NACK: begin
            if (avail) begin
              rv = 1'b1;
              rd = item_rx;
              ri = position[7:0];
              position_next = position + 9'd1;
              transfer_count_next = transfer_count + 9'd1;
            end
            cmd = CMD_STOP;
            mode_next = MODE_IDLE;
            done = DONE_READ;
          end
          STS_ST_SLA_ACK, STS_ST_ARB_LOST_SLA_ACK: begin
            if (!slave_on) begin
              cmd = CMD_IDLE;
            end else begin
              end_position_next = clamp_len(cfg.slave_tx_length);
              mode_next = MODE_ST;
              if (end_position_next != 9'd0) begin
                send = ram_rdata;
                cmd = CMD_ACK;
                position_next = 9'd1;
                transfer_count_next = 9'd1;
              end else begin
                cmd = CMD_NACK;
                position_next = 9'd0;
                transfer_count_next = 9'd0;
              end
            end
          end
          STS_ST_DATA_ACK: begin
            if (avail) begin
              send = ram_rdata;
              cmd = CMD_ACK;
              position_next = position + 9'd1;
              transfer_count_next = transfer_count + 9'd1;
            end else begin
              cmd = CMD_NACK;
            end
          end
          STS_ST_DATA_NACK, STS_ST_LAST_DATA: begin
            cmd = CMD_ACK;
            mode_next = MODE_IDLE;
          end
          STS_SR_SLA_ACK, STS_SR_ARB_LOST_SLA_ACK, STS_SR_GCALL_ACK,
          STS_SR_ARB_LOST_GCALL_ACK: begin
            if (!slave_on) begin
              cmd = CMD_IDLE;
            end else begin
              position_next = 9'd0;
              end_position_next = clamp_len(cfg.slave_rx_limit);
              transfer_count_next = 9'd0;
              mode_next = MODE_SR;
              cmd = CMD_ACK;
            end
          end
          STS_SR_DATA_ACK, STS_SR_GCALL_DATA_ACK: begin
            if (avail) begin
              rv = 1'b1;
              rd = item_rx;
              ri = position[7:0];
              position_next = position + 9'd1;
              transfer_count_next = transfer_count + 9'd1;
              cmd = CMD_ACK;
            end else begin
              cmd = CMD_NACK;
            end
          end
          STS_SR_DATA_NACK, STS_SR_GCALL_DATA_NACK: begin
            cmd = CMD_NACK;
          end
          STS_SR_STOP: begin
            cmd = CMD_STOP;
            mode_next = MODE_IDLE;
            done = DONE_WRITE;
            slave_enabled_next = 1'b0;
          end
          STS_NO_INFO: begin
            cmd = CMD_NONE;
          end
          STS_BUS_ERROR: begin
            cmd = CMD_STOP;
            mode_next = MODE_ERROR;
            error_flag_next = 1'b1;
          end
          default: begin
            cmd = CMD_IDLE;
          end
        endcase
      end
      OP_SERVICE_DONE: begin
        slave_enabled_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      strobe <= 1'b0;
      position <= '0;
      end_position <= '0;
      transfer_count <= '0;
      mode <= MODE_IDLE;
      request_address <= '0;
      slave_enabled <= 1'b1;
      error_flag <= 1'b0;
    end else begin
      strobe <= pend;
      if (accept) begin
        pend <= 1'b1;
      end else if (pend) begin
        pend <= 1'b0;
      end
      if (pend) begin
        position <= position_next;
        end_position <= end_position_next;
        transfer_count <= transfer_count_next;
        mode <= mode_next;
        request_address <= request_address_next;
        slave_enabled <= slave_enabled_next;
        error_flag <= error_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op <= op_t'(op);
      item_status <= bus_status;
      item_rx <= received_byte;
      item_li <= load_index;
      item_lb <= load_byte;
      item_ta <= target_address;
      item_tl <= transfer_length;
    end
    if (pend) begin
      bus_command <= cmd;
      send_byte <= send;
      received_valid <= rv;
      received_data <= rd;
      received_index <= ri;
      done_event <= done;
      byte_count <= error_flag_next ? 9'd0 : transfer_count_next;
      failed <= error_flag_next;
      busy_res <= (mode_next inside {MODE_MT, MODE_MR, MODE_ST, MODE_SR});
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    position <= end_position)
    else $error("position beyond end of segment");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    pend |=> (strobe && !pend))
    else $error("item did not complete in one processing cycle");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !pend |=> ($stable(mode) && $stable(position) && $stable(transfer_count)))
    else $error("state changed without an item in progress");

  a_failed_count: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(failed && (byte_count != 9'd0)))
    else $error("count reported on a failed transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_slave_transaction_sequencer_top.sv =====
// pipeline: an accepted item is captured into the item registers, decided while
//   busy, and registered onto the result ports, marked by strobe for one cycle
// handshake: start is ignored while busy; busy is high for the cycle in which the
//   transmit memory read completes and the item is decided
// reset: synchronous, clears sequencer state, strobe and config; result ports and
//   transmit memory are not cleared; memory holds undefined bytes until loaded
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_slave_transaction_sequencer_top
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            op,
  input  wire logic [4:0]            bus_status,
  input  wire logic [7:0]            received_byte,
  input  wire logic [7:0]            load_index,
  input  wire logic [7:0]            load_byte,
  input  wire logic [7:0]            target_address,
  input  wire logic [8:0]            transfer_length,
  output logic                       strobe,
  output logic      [2:0]            bus_command,
  output logic      [7:0]            send_byte,
  output logic                       received_valid,
  output logic      [7:0]            received_data,
  output logic      [7:0]            received_index,
  output logic      [1:0]            done_event,
  output logic      [8:0]            byte_count,
  output logic                       failed,
  output logic                       busy_res,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AW = $clog2(BUF_DEPTH);

  cfg_t          cfg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  i2cms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_txmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  i2cms_seq #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .bus_status      (bus_status),
    .received_byte   (received_byte),
    .load_index      (load_index),
    .load_byte       (load_byte),
    .target_address  (target_address),
    .transfer_length (transfer_length),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .strobe          (strobe),
    .bus_command     (bus_command),
    .send_byte       (send_byte),
    .received_valid  (received_valid),
    .received_data   (received_data),
    .received_index  (received_index),
    .done_event      (done_event),
    .byte_count      (byte_count),
    .failed          (failed),
    .busy_res        (busy_res)
  );

endmodule

`default_nettype wire
